[sv/shfe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shfe_pkg
// Types, constants and helper functions for the syslog header extractor.
// ----------------------------------------------------------------------------
package shfe_pkg;

  localparam int MAX_MSG_LEN = 65535;
  localparam int PRI_WINDOW  = 6;
  localparam int OFF_W       = $clog2(MAX_MSG_LEN + 1);
  localparam int OUT_W       = 16;
  localparam int PRI_W       = 14;
  localparam int PROD_W      = PRI_W + 4;
  localparam int FAC_W       = 5;
  localparam int SEV_W       = 3;
  localparam int FAC_LIMIT   = 24;

  localparam logic [PRI_W-1:0] PRI_CAP       = '1;
  localparam logic [PRI_W-1:0] PRI_FAC_LIMIT = PRI_W'(FAC_LIMIT << SEV_W);
  localparam logic [1:0]       HOST_SPACES   = 2'd3;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef enum logic [3:0] {
    PH_START,
    PH_PRI,
    PH_FIRST,
    PH_3164,
    PH_VER,
    PH_TS,
    PH_HOST,
    PH_APP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic             vld;
    logic [OFF_W-1:0] at;
  } mark_t;

  typedef struct packed {
    mark_t colon;
    mark_t brk;
  } tagscan_t;

  typedef struct packed {
    logic [OFF_W-1:0] body_start;
    logic [1:0]       space_cnt;
    mark_t            first_end;
    logic [OFF_W-1:0] host_start;
    mark_t            host_stop;
    tagscan_t         tag;
    tagscan_t         fb;
  } trk_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic tagscan_t scan_tag(tagscan_t s, logic [OFF_W-1:0] o, logic [7:0] c);
    tagscan_t r;
    r = s;
    if (!s.colon.vld) begin
      if (c == CH_COLON) begin
        r.colon.vld = 1'b1;
        r.colon.at  = o;
      end else if ((c == CH_LBRK) && !s.brk.vld) begin
        r.brk.vld = 1'b1;
        r.brk.at  = o;
      end
    end
    return r;
  endfunction

  function automatic trk_t restart_trk(logic [OFF_W-1:0] start);
    trk_t r;
    r            = '0;
    r.body_start = start;
    return r;
  endfunction

  function automatic trk_t feed_3164(trk_t t, logic [OFF_W-1:0] o, logic [7:0] c);
    trk_t r;
    r = t;
    if (t.space_cnt != HOST_SPACES) begin
      if (t.first_end.vld) begin
        r.fb = scan_tag(t.fb, o, c);
      end
      if (c == CH_SP) begin
        if (t.space_cnt == 2'd0) begin
          r.first_end.vld = 1'b1;
          r.first_end.at  = o;
        end
        r.space_cnt = t.space_cnt + 2'd1;
        if (t.space_cnt == (HOST_SPACES - 2'd1)) begin
          r.host_start = o + OFF_W'(1);
        end
      end
    end else if (!t.host_stop.vld) begin
      if (c == CH_SP) begin
        r.host_stop.vld = 1'b1;
        r.host_stop.at  = o;
      end
    end else begin
      r.tag = scan_tag(t.tag, o, c);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/syslog_header_field_extractor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// syslog_header_field_extractor
// Byte-serial syslog header parser (RFC 3164 / RFC 5424).
// ----------------------------------------------------------------------------
// One message byte is taken per cycle, back to back, with no gaps between
// messages, save where an end-of-message byte stalls as told below. Each byte
// passes an input register, then one pass of parse logic updates the
// per-message state; on the byte flagged end_of_message the result is formed
// from that updated state and loaded into the output register.
// The output register decouples the sides: bytes keep flowing while a result
// waits, and only a second end-of-message byte stalls behind an untaken result.
// Offsets saturate at 65535 bytes; later bytes only count for their end mark.
// ----------------------------------------------------------------------------
module syslog_header_field_extractor (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [7:0]                in_data_byte,
  input  wire logic                      in_end_of_message,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic                      out_facility_known,
  output      logic [shfe_pkg::FAC_W-1:0] out_facility,
  output      logic [shfe_pkg::SEV_W-1:0] out_severity,
  output      logic                      out_is_rfc5424,
  output      logic                      out_host_found,
  output      logic                      out_host_unknown,
  output      logic [shfe_pkg::OUT_W-1:0] out_host_start,
  output      logic [shfe_pkg::OUT_W-1:0] out_host_length,
  output      logic                      out_source_found,
  output      logic [shfe_pkg::OUT_W-1:0] out_source_start,
  output      logic [shfe_pkg::OUT_W-1:0] out_source_length
);
  import shfe_pkg::*;

  // input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_eom_r;
  logic       s1_go;
  logic       out_ok;
  logic       in_accept;

  // message state
  phase_t            ph_r, ph_nxt, ph_u;
  logic [OFF_W-1:0]  off_r, off_nxt, off_u;
  logic [PRI_W-1:0]  acc_r, acc_nxt, acc_u;
  logic              seen_r, seen_nxt, seen_u;
  logic              dopen_r, dopen_nxt, dopen_u;
  logic              pok_r, pok_nxt, pok_u;
  trk_t              trk_r, trk_nxt, trk_u;
  logic [OFF_W-1:0]  app_r, app_nxt, app_u;
  logic              hdash_r, hdash_nxt, hdash_u;
  logic              adash_r, adash_nxt, adash_u;

  logic [PROD_W-1:0] prod;
  logic [7:0]        c;
  logic [OFF_W-1:0]  o;
  logic              sp;

  // result
  logic              fk, v5, hf, hu, sf, three;
  logic [OFF_W-1:0]  hs, hl, ss, sl, ts, te, alen;
  mark_t             he, col, br;

  // output register
  logic                   out_valid_r;
  logic                   fk_r, v5_r, hf_r, hu_r, sf_r;
  logic [FAC_W-1:0]       fac_r;
  logic [SEV_W-1:0]       sev_r;
  logic [OUT_W-1:0]       hs_r, hl_r, ss_r, sl_r;

  assign out_ok    = !out_valid_r || !out_stall;
  assign s1_go     = s1_vld_r && (!s1_eom_r || out_ok);
  assign in_stall  = s1_vld_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  assign c    = s1_byte_r;
  assign o    = off_r;
  assign sp   = (c == CH_SP);
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
              + PROD_W'(c - CH_0);

  // per-byte parse
  always_comb begin
    ph_u    = ph_r;
    off_u   = off_r;
    acc_u   = acc_r;
    seen_u  = seen_r;
    dopen_u = dopen_r;
    pok_u   = pok_r;
    trk_u   = trk_r;
    app_u   = app_r;
    hdash_u = hdash_r;
    adash_u = adash_r;
    if (off_r < OFF_W'(MAX_MSG_LEN)) begin
      off_u = off_r + OFF_W'(1);
      unique case (ph_r)
        PH_START: begin
          if (c == CH_LT) begin
            ph_u    = PH_PRI;
            dopen_u = 1'b1;
            trk_u   = feed_3164(trk_r, o, c);
          end else if (is_digit(c)) begin
            ph_u = PH_VER;
          end else begin
            ph_u  = PH_3164;
            trk_u = feed_3164(trk_r, o, c);
          end
        end
        PH_PRI: begin
          if (o >= OFF_W'(PRI_WINDOW)) begin
            ph_u  = PH_3164;
            trk_u = feed_3164(trk_r, o, c);
          end else if (c == CH_GT) begin
            pok_u = seen_r;
            trk_u = restart_trk(o + OFF_W'(1));
            ph_u  = PH_FIRST;
          end else begin
            if (dopen_r && is_digit(c)) begin
              acc_u  = (prod > PROD_W'(PRI_CAP)) ? PRI_CAP : prod[PRI_W-1:0];
              seen_u = 1'b1;
            end else begin
              dopen_u = 1'b0;
            end
            trk_u = feed_3164(trk_r, o, c);
          end
        end
        PH_FIRST: begin
          if (is_digit(c)) begin
            ph_u = PH_VER;
          end else begin
            ph_u  = PH_3164;
            trk_u = feed_3164(trk_r, o, c);
          end
        end
        PH_3164: begin
          trk_u = feed_3164(trk_r, o, c);
        end
        PH_VER: begin
          if (sp) ph_u = PH_TS;
        end
        PH_TS: begin
          if (sp) begin
            trk_u.host_start = o + OFF_W'(1);
            ph_u             = PH_HOST;
          end
        end
        PH_HOST: begin
          if (o == trk_r.host_start) hdash_u = (c == CH_DASH);
          if (sp) begin
            trk_u.host_stop.vld = 1'b1;
            trk_u.host_stop.at  = o;
            app_u               = o + OFF_W'(1);
            ph_u                = PH_APP;
          end
        end
        PH_APP: begin
          if (o == app_r) adash_u = (c == CH_DASH);
          if (sp) begin
            trk_u.tag.colon.vld = 1'b1;
            trk_u.tag.colon.at  = o;
            ph_u                = PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result from the updated state
  always_comb begin
    fk    = pok_u && (acc_u < PRI_FAC_LIMIT);
    v5    = (ph_u == PH_VER) || (ph_u == PH_TS) || (ph_u == PH_HOST)
         || (ph_u == PH_APP) || (ph_u == PH_DONE);
    three = (trk_u.space_cnt == HOST_SPACES);
    he    = three ? trk_u.host_stop : trk_u.first_end;
    col   = three ? trk_u.tag.colon : trk_u.fb.colon;
    br    = three ? trk_u.tag.brk   : trk_u.fb.brk;
    ts    = he.at + OFF_W'(1);
    te    = br.vld ? br.at : col.at;
    alen  = trk_u.tag.colon.at - app_u;
    hf    = 1'b0;
    hu    = 1'b0;
    sf    = 1'b0;
    hs    = '0;
    hl    = '0;
    ss    = '0;
    sl    = '0;
    if (v5) begin
      if (trk_u.host_stop.vld) begin
        hf = 1'b1;
        hs = trk_u.host_start;
        hl = trk_u.host_stop.at - trk_u.host_start;
        hu = (hl == OFF_W'(1)) && hdash_u;
      end
      if (trk_u.tag.colon.vld && !((alen == OFF_W'(1)) && adash_u)) begin
        sf = 1'b1;
        ss = app_u;
        sl = alen;
      end
    end else if (he.vld) begin
      hf = 1'b1;
      hs = three ? trk_u.host_start : trk_u.body_start;
      hl = he.at - hs;
      if (col.vld && (te > ts)) begin
        sf = 1'b1;
        ss = ts;
        sl = te - ts;
      end
    end
  end

  always_comb begin
    ph_nxt    = ph_r;
    off_nxt   = off_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    dopen_nxt = dopen_r;
    pok_nxt   = pok_r;
    trk_nxt   = trk_r;
    app_nxt   = app_r;
    hdash_nxt = hdash_r;
    adash_nxt = adash_r;
    if (s1_go) begin
      if (s1_eom_r) begin
        ph_nxt    = PH_START;
        off_nxt   = '0;
        acc_nxt   = '0;
        seen_nxt  = 1'b0;
        dopen_nxt = 1'b0;
        pok_nxt   = 1'b0;
        trk_nxt   = restart_trk('0);
        app_nxt   = '0;
        hdash_nxt = 1'b0;
        adash_nxt = 1'b0;
      end else begin
        ph_nxt    = ph_u;
        off_nxt   = off_u;
        acc_nxt   = acc_u;
        seen_nxt  = seen_u;
        dopen_nxt = dopen_u;
        pok_nxt   = pok_u;
        trk_nxt   = trk_u;
        app_nxt   = app_u;
        hdash_nxt = hdash_u;
        adash_nxt = adash_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ph_r        <= PH_START;
      off_r       <= '0;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      dopen_r     <= 1'b0;
      pok_r       <= 1'b0;
      trk_r       <= restart_trk('0);
      app_r       <= '0;
      hdash_r     <= 1'b0;
      adash_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_go && s1_eom_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      ph_r    <= ph_nxt;
      off_r   <= off_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      dopen_r <= dopen_nxt;
      pok_r   <= pok_nxt;
      trk_r   <= trk_nxt;
      app_r   <= app_nxt;
      hdash_r <= hdash_nxt;
      adash_r <= adash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data_byte;
      s1_eom_r  <= in_end_of_message;
    end
    if (s1_go && s1_eom_r) begin
      fk_r  <= fk;
      fac_r <= fk ? acc_u[SEV_W +: FAC_W] : '0;
      sev_r <= fk ? acc_u[SEV_W-1:0] : '0;
      v5_r  <= v5;
      hf_r  <= hf;
      hu_r  <= hu;
      hs_r  <= OUT_W'(hs);
      hl_r  <= OUT_W'(hl);
      sf_r  <= sf;
      ss_r  <= OUT_W'(ss);
      sl_r  <= OUT_W'(sl);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_facility_known = fk_r;
  assign out_facility       = fac_r;
  assign out_severity       = sev_r;
  assign out_is_rfc5424     = v5_r;
  assign out_host_found     = hf_r;
  assign out_host_unknown   = hu_r;
  assign out_host_start     = hs_r;
  assign out_host_length    = hl_r;
  assign out_source_found   = sf_r;
  assign out_source_start   = ss_r;
  assign out_source_length  = sl_r;

endmodule
`default_nettype wire

[sv/shfe_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shfe_chk
// Port-level checks for the syslog header extractor.
// ----------------------------------------------------------------------------
module shfe_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [7:0]                 in_data_byte,
  input wire logic                       in_end_of_message,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic                       out_facility_known,
  input wire logic [shfe_pkg::FAC_W-1:0] out_facility,
  input wire logic [shfe_pkg::SEV_W-1:0] out_severity,
  input wire logic                       out_is_rfc5424,
  input wire logic                       out_host_found,
  input wire logic                       out_host_unknown,
  input wire logic [shfe_pkg::OUT_W-1:0] out_host_start,
  input wire logic [shfe_pkg::OUT_W-1:0] out_host_length,
  input wire logic                       out_source_found,
  input wire logic [shfe_pkg::OUT_W-1:0] out_source_start,
  input wire logic [shfe_pkg::OUT_W-1:0] out_source_length
);
  import shfe_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_fac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_facility_known && (out_facility < FAC_W'(FAC_LIMIT)))
               || (!out_facility_known && (out_facility == '0) && (out_severity == '0)))
    else $error("facility/severity inconsistent with facility_known");

  a_host_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_host_found |->
      (out_host_start == '0) && (out_host_length == '0) && !out_host_unknown)
    else $error("host fields set without a host");

  a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_source_found |->
      (out_source_start == '0) && (out_source_length == '0))
    else $error("source fields set without a source");

  a_dash_5424: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_host_unknown |-> out_is_rfc5424 && (out_host_length == OUT_W'(1)))
    else $error("unknown host outside the RFC 5424 path");

endmodule

bind syslog_header_field_extractor shfe_chk u_shfe_chk (.*);
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the syslog header field extractor. A queue of
// directed and random syslog messages is fed byte by byte; a local parser
// predicts the header fields of each message, and every output transaction
// is compared field by field against the oldest prediction. Both sides
// idle and stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;
  import shfe_pkg::*;

  localparam int CALM_ITEMS  = 200;
  localparam int HOLD_AT     = 30;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic             vld;
    logic [OFF_W-1:0] at;
  } pos_mark_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
    logic       drain;
  } byte_item_t;

  typedef struct packed {
    logic             facility_known;
    logic [FAC_W-1:0] facility;
    logic [SEV_W-1:0] severity;
    logic             is_rfc5424;
    logic             host_found;
    logic             host_unknown;
    logic [OUT_W-1:0] host_start;
    logic [OUT_W-1:0] host_length;
    logic             source_found;
    logic [OUT_W-1:0] source_start;
    logic [OUT_W-1:0] source_length;
  } header_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte = '0;
  logic             in_end_of_message = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_facility_known;
  logic [FAC_W-1:0] out_facility;
  logic [SEV_W-1:0] out_severity;
  logic             out_is_rfc5424;
  logic             out_host_found;
  logic             out_host_unknown;
  logic [OUT_W-1:0] out_host_start;
  logic [OUT_W-1:0] out_host_length;
  logic             out_source_found;
  logic [OUT_W-1:0] out_source_start;
  logic [OUT_W-1:0] out_source_length;

  syslog_header_field_extractor u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_end_of_message  (in_end_of_message),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_facility_known (out_facility_known),
    .out_facility       (out_facility),
    .out_severity       (out_severity),
    .out_is_rfc5424     (out_is_rfc5424),
    .out_host_found     (out_host_found),
    .out_host_unknown   (out_host_unknown),
    .out_host_start     (out_host_start),
    .out_host_length    (out_host_length),
    .out_source_found   (out_source_found),
    .out_source_start   (out_source_start),
    .out_source_length  (out_source_length)
  );

  byte_item_t     pending_bytes[$];
  header_result_t expected_headers[$];
  logic [7:0]     msg_buf[$];
  int             fail_count = 0;

  // ---------------- header parser model ----------------
  phase_t           hdr_phase;
  int unsigned      msg_offset;
  int unsigned      pri_value;
  bit               pri_seen, pri_digits, pri_ok;
  logic [OFF_W-1:0] body_start, host_start, app_start;
  int unsigned      spaces;
  pos_mark_t        first_end, host_stop, tag_end, tag_brk, fb_colon, fb_brk;
  bit               host_dash, app_dash;

  function automatic bit numeral(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  task automatic restart_scan(input logic [OFF_W-1:0] start);
    body_start = start;
    spaces     = 0;
    first_end  = '0;
    host_start = '0;
    host_stop  = '0;
    tag_end    = '0;
    tag_brk    = '0;
    fb_colon   = '0;
    fb_brk     = '0;
  endtask

  task automatic clear_parser();
    hdr_phase  = PH_START;
    msg_offset = 0;
    pri_value  = 0;
    pri_seen   = 1'b0;
    pri_digits = 1'b0;
    pri_ok     = 1'b0;
    app_start  = '0;
    host_dash  = 1'b0;
    app_dash   = 1'b0;
    restart_scan('0);
  endtask

  task automatic seek_tag(inout pos_mark_t colon, inout pos_mark_t brk,
                          input logic [OFF_W-1:0] o, input logic [7:0] c);
    if (!colon.vld) begin
      if (c == CH_COLON) begin
        colon.vld = 1'b1;
        colon.at  = o;
      end else if (c == CH_LBRK && !brk.vld) begin
        brk.vld = 1'b1;
        brk.at  = o;
      end
    end
  endtask

  task automatic feed_legacy(input logic [OFF_W-1:0] o, input logic [7:0] c);
    if (spaces < 3) begin
      if (first_end.vld) seek_tag(fb_colon, fb_brk, o, c);
      if (c == CH_SP) begin
        if (spaces == 0) begin
          first_end.vld = 1'b1;
          first_end.at  = o;
        end
        spaces++;
        if (spaces == 3) host_start = o + 1'b1;
      end
    end else if (!host_stop.vld) begin
      if (c == CH_SP) begin
        host_stop.vld = 1'b1;
        host_stop.at  = o;
      end
    end else begin
      seek_tag(tag_end, tag_brk, o, c);
    end
  endtask

  task automatic step_phase(input logic [OFF_W-1:0] o, input logic [7:0] c);
    case (hdr_phase)
      PH_START: begin
        if (c == CH_LT) begin
          hdr_phase  = PH_PRI;
          pri_digits = 1'b1;
          feed_legacy(o, c);
        end else if (numeral(c)) begin
          hdr_phase = PH_VER;
        end else begin
          hdr_phase = PH_3164;
          feed_legacy(o, c);
        end
      end
      PH_PRI: begin
        if (o >= PRI_WINDOW) begin
          hdr_phase = PH_3164;
          feed_legacy(o, c);
        end else if (c == CH_GT) begin
          pri_ok = pri_seen;
          restart_scan(o + 1'b1);
          hdr_phase = PH_FIRST;
        end else begin
          if (pri_digits && numeral(c)) begin
            pri_value = pri_value * 10 + (c - CH_0);
            if (pri_value > PRI_CAP) pri_value = PRI_CAP;
            pri_seen = 1'b1;
          end else begin
            pri_digits = 1'b0;
          end
          feed_legacy(o, c);
        end
      end
      PH_FIRST: begin
        if (numeral(c)) begin
          hdr_phase = PH_VER;
        end else begin
          hdr_phase = PH_3164;
          feed_legacy(o, c);
        end
      end
      PH_3164: feed_legacy(o, c);
      PH_VER: if (c == CH_SP) hdr_phase = PH_TS;
      PH_TS: begin
        if (c == CH_SP) begin
          host_start = o + 1'b1;
          hdr_phase  = PH_HOST;
        end
      end
      PH_HOST: begin
        if (o == host_start) host_dash = (c == CH_DASH);
        if (c == CH_SP) begin
          host_stop.vld = 1'b1;
          host_stop.at  = o;
          app_start     = o + 1'b1;
          hdr_phase     = PH_APP;
        end
      end
      PH_APP: begin
        if (o == app_start) app_dash = (c == CH_DASH);
        if (c == CH_SP) begin
          tag_end.vld = 1'b1;
          tag_end.at  = o;
          hdr_phase   = PH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic form_result(output header_result_t r);
    bit          fk, three;
    pos_mark_t   he, col, br;
    int unsigned hs, hl, ts, te, len;
    r  = '0;
    fk = pri_ok && ((pri_value >> SEV_W) < FAC_LIMIT);
    if (fk) begin
      r.facility_known = 1'b1;
      r.facility       = FAC_W'(pri_value >> SEV_W);
      r.severity       = pri_value[SEV_W-1:0];
    end
    if (hdr_phase >= PH_VER) begin
      r.is_rfc5424 = 1'b1;
      if (host_stop.vld) begin
        hl = host_stop.at - host_start;
        r.host_found   = 1'b1;
        r.host_start   = host_start;
        r.host_length  = OUT_W'(hl);
        r.host_unknown = (hl == 1) && host_dash;
      end
      if (tag_end.vld) begin
        len = tag_end.at - app_start;
        if (!(len == 1 && app_dash)) begin
          r.source_found  = 1'b1;
          r.source_start  = app_start;
          r.source_length = OUT_W'(len);
        end
      end
    end else begin
      three = (spaces == 3);
      he    = three ? host_stop : first_end;
      col   = three ? tag_end : fb_colon;
      br    = three ? tag_brk : fb_brk;
      if (he.vld) begin
        hs = three ? host_start : body_start;
        r.host_found  = 1'b1;
        r.host_start  = OUT_W'(hs);
        r.host_length = OUT_W'(he.at - hs);
        if (col.vld) begin
          ts = he.at + 1;
          te = br.vld ? br.at : col.at;
          if (te > ts) begin
            r.source_found  = 1'b1;
            r.source_start  = OUT_W'(ts);
            r.source_length = OUT_W'(te - ts);
          end
        end
      end
    end
  endtask

  task automatic absorb_byte(input logic [7:0] c, input logic eom);
    header_result_t r;
    if (msg_offset < MAX_MSG_LEN) begin
      step_phase(msg_offset[OFF_W-1:0], c);
      msg_offset++;
    end
    if (eom) begin
      form_result(r);
      expected_headers.push_back(r);
      clear_parser();
    end
  endtask

  // ---------------- message builders ----------------
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
  endfunction

  function automatic void add_number(int unsigned lo, int unsigned hi);
    add_text($sformatf("%0d", $urandom_range(hi, lo)));
  endfunction

  function automatic void add_word(int lo, int hi);
    string alpha;
    int    n;
    alpha = "abcdefghijklmnopqrstuvwxyzABCXYZ0123456789.-_/";
    n     = $urandom_range(hi, lo);
    for (int i = 0; i < n; i++) msg_buf.push_back(alpha[$urandom_range(alpha.len() - 1, 0)]);
  endfunction

  function automatic logic [7:0] odd_byte();
    string specials;
    specials = "<>:[] -0123456789ab";
    if ($urandom_range(1, 0)) return 8'($urandom_range(255, 0));
    return specials[$urandom_range(specials.len() - 1, 0)];
  endfunction

  function automatic void add_header();
    if ($urandom_range(3, 0) != 0) begin
      add_text("<");
      if ($urandom_range(3, 0) != 0) add_number(0, 191);
      else add_number(0, 99999);
      add_text(">");
    end
  endfunction

  function automatic void build_legacy();
    add_header();
    if ($urandom_range(3, 0) != 0) begin
      add_word(3, 3);
      add_text(" ");
      add_number(1, 31);
      add_text(" ");
      add_word(8, 8);
      add_text(" ");
    end
    add_word(1, 12);
    add_text(" ");
    add_word(0, 8);
    if ($urandom_range(1, 0)) begin
      add_text("[");
      add_number(0, 9999);
      add_text("]");
    end
    add_text(": ");
    add_word(0, 20);
  endfunction

  function automatic void add_field();
    case ($urandom_range(3, 0))
      0: add_text("-");
      1: ;
      default: add_word(1, 16);
    endcase
  endfunction

  function automatic void build_structured();
    add_header();
    if ($urandom_range(7, 0) != 0) add_number(1, 9);
    else add_number(10, 99);
    add_text(" ");
    if ($urandom_range(3, 0) != 0) add_word(1, 24);
    else add_text("-");
    add_text(" ");
    add_field();
    add_text(" ");
    add_field();
    add_text(" ");
    add_word(0, 12);
    if ($urandom_range(1, 0)) add_text(" - msg");
  endfunction

  function automatic void add_noise();
    int n;
    n = $urandom_range(40, 1);
    for (int i = 0; i < n; i++) msg_buf.push_back(odd_byte());
  endfunction

  function automatic void break_message();
    int keep;
    if ($urandom_range(1, 0) && msg_buf.size() > 1) begin
      keep    = $urandom_range(msg_buf.size() - 1, 1);
      msg_buf = msg_buf[0:keep-1];
    end else begin
      for (int i = $urandom_range(3, 1); i > 0; i--)
        msg_buf[$urandom_range(msg_buf.size() - 1, 0)] = odd_byte();
    end
  endfunction

  function automatic void post_message(bit drain);
    byte_item_t it;
    for (int i = 0; i < msg_buf.size(); i++) begin
      it.data  = msg_buf[i];
      it.eom   = (i == msg_buf.size() - 1);
      it.drain = drain && (i == 0);
      pending_bytes.push_back(it);
    end
    msg_buf.delete();
  endfunction

  function automatic void post_text(string s);
    add_text(s);
    post_message(1'b0);
  endfunction

  // ---------------- clock, stimulus, end of run ----------------
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("syslog_header_field_extractor: mismatch");
    $finish;
  end

  initial begin
    int random_bytes, random_msgs, kind;
    clear_parser();
    post_text("<34>Oct 11 22:14:15 mymachine su: 'su root' failed on /dev/pts/8");
    post_text("<165>1 2003-10-11T22:14:15.003Z mymachine.example.com evntslog - ID47 - m");
    post_text("<13>1 2024-01-01T00:00:00Z - - - x");
    post_text("<13>1 ts   rest");
    post_text("1 ts host app rest");
    post_text("<>abc def: hello");
    post_text("<x>myhost tag: m");
    post_text("<123456 host proc[99]: m");
    post_text("<12345>host: m");
    post_text("<9999>x y z host app: m");
    post_text("<191>host tag[7]: m");
    post_text("<0>a b c host : m");
    post_text("<192>a b c host tag:");
    post_text("x");
    post_text("<");
    post_text("7");
    msg_buf.push_back(8'h00);
    msg_buf.push_back(8'hFF);
    msg_buf.push_back(8'h80);
    msg_buf.push_back(8'h7F);
    post_text(" a:b [c");
    post_text("<13>1 ts host");
    post_text("<23>1 ts h app");

    random_bytes = 0;
    random_msgs  = 0;
    while (random_bytes < 1000 || random_msgs < 40) begin
      kind = $urandom_range(19, 0);
      if (kind < 7) begin
        build_legacy();
      end else if (kind < 14) begin
        build_structured();
      end else if (kind < 17) begin
        add_noise();
      end else begin
        if (kind == 17) build_legacy();
        else build_structured();
        break_message();
      end
      random_bytes += msg_buf.size();
      post_message(random_msgs == 0);
      random_msgs++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("syslog_header_field_extractor: match");
    end else begin
      $display("syslog_header_field_extractor: mismatch");
    end
    $finish;
  end

  // ---------------- driver ----------------
  int         gap_left = 0;
  byte_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_byte(in_data_byte, in_end_of_message);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() == 0 ||
                     (pending_bytes[0].drain && expected_headers.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > CALM_ITEMS && $urandom_range(5, 0) == 0) begin
          gap_left = $urandom_range(7, 1) - 1;
          in_valid <= 1'b0;
        end else begin
          next_item = pending_bytes.pop_front();
          in_valid          <= 1'b1;
          in_data_byte      <= next_item.data;
          in_end_of_message <= next_item.eom;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int             stall_left = 0;
  int             hold_left = 0;
  int             results_seen = 0;
  header_result_t want;

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_headers.size() == 0) begin
          $error("out transaction with no expected result");
          fail_count++;
        end else begin
          want = expected_headers.pop_front();
          check_field("facility_known", want.facility_known, out_facility_known);
          check_field("facility", want.facility, out_facility);
          check_field("severity", want.severity, out_severity);
          check_field("is_rfc5424", want.is_rfc5424, out_is_rfc5424);
          check_field("host_found", want.host_found, out_host_found);
          check_field("host_unknown", want.host_unknown, out_host_unknown);
          check_field("host_start", want.host_start, out_host_start);
          check_field("host_length", want.host_length, out_host_length);
          check_field("source_found", want.source_found, out_source_found);
          check_field("source_start", want.source_start, out_source_start);
          check_field("source_length", want.source_length, out_source_length);
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (pending_bytes.size() > CALM_ITEMS && $urandom_range(5, 0) == 0) begin
        stall_left = $urandom_range(7, 1) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

endmodule
